### src/ifd_pkg.sv
// ----------------------------------------------------------------------------
// ifd_pkg: shared types and codes for the instruction fetch/decode block
// Status codes, instruction codes, register limits and field widths.
// ----------------------------------------------------------------------------
package ifd_pkg;

  localparam int unsigned ADDR_W     = 64;
  localparam int unsigned WORD_W     = 64;
  localparam int unsigned MSIZE_W    = 17;
  localparam int unsigned NIB_W      = 4;

  localparam logic [MSIZE_W-1:0] MSIZE_RESET = 17'd4096;

  // 8-byte constant field length
  localparam logic [3:0] CONST_BYTES = 4'd8;

  localparam logic [NIB_W-1:0] NO_REG  = 4'hF;
  localparam logic [NIB_W-1:0] TOP_REG = 4'hE;

  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_ADR = 2'd1,
    ST_INS = 2'd2
  } status_t;

  localparam logic [NIB_W-1:0] CODE_HALT   = 4'h0;
  localparam logic [NIB_W-1:0] CODE_NOP    = 4'h1;
  localparam logic [NIB_W-1:0] CODE_CMOV   = 4'h2;
  localparam logic [NIB_W-1:0] CODE_IRMOV  = 4'h3;
  localparam logic [NIB_W-1:0] CODE_RMMOV  = 4'h4;
  localparam logic [NIB_W-1:0] CODE_MRMOV  = 4'h5;
  localparam logic [NIB_W-1:0] CODE_OPQ    = 4'h6;
  localparam logic [NIB_W-1:0] CODE_JXX    = 4'h7;
  localparam logic [NIB_W-1:0] CODE_CALL   = 4'h8;
  localparam logic [NIB_W-1:0] CODE_RET    = 4'h9;
  localparam logic [NIB_W-1:0] CODE_PUSH   = 4'hA;
  localparam logic [NIB_W-1:0] CODE_POP    = 4'hB;
  localparam logic [NIB_W-1:0] CODE_IOTRAP = 4'hC;

  // highest legal function nibble per code family
  localparam logic [NIB_W-1:0] FN_MAX_NONE = 4'd0;
  localparam logic [NIB_W-1:0] FN_MAX_COND = 4'd6;
  localparam logic [NIB_W-1:0] FN_MAX_OPQ  = 4'd3;
  localparam logic [NIB_W-1:0] FN_MAX_TRAP = 4'd5;

endpackage

### src/instruction_fetch_decode_top.sv
// ----------------------------------------------------------------------------
// instruction_fetch_decode_top: one-instruction fetch and decode
// Path: input register, then decode logic into the result register.
// Throughput: 1 instruction per cycle while out_ready is high; set by the
//   single decode pass between the two registers, with the result register
//   draining as the input fills.
// Reset: rst_n synchronous, active low; empties both stages and sets
//   memory_size to 4096.
// ----------------------------------------------------------------------------
module instruction_fetch_decode_top (
  input  logic        clk,
  input  logic        rst_n,

  // configuration: memory size in bytes
  input  logic        cfg_wr_en,
  input  logic [16:0] cfg_wr_data,

  // instruction window
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] in_fetch_address,
  input  logic [7:0]  in_opcode_byte,
  input  logic [7:0]  in_register_byte,
  input  logic [63:0] in_word_after_opcode,
  input  logic [63:0] in_word_after_registers,

  // decoded instruction
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [3:0]  out_instr_code,
  output logic [3:0]  out_instr_function,
  output logic [3:0]  out_reg_a,
  output logic [3:0]  out_reg_b,
  output logic [63:0] out_constant_value,
  output logic [63:0] out_next_address
);

  localparam int unsigned AW = ifd_pkg::ADDR_W;
  localparam int unsigned WW = ifd_pkg::WORD_W;
  localparam int unsigned MW = ifd_pkg::MSIZE_W;
  localparam int unsigned NW = ifd_pkg::NIB_W;

  // --------------------------------------------------------------------------
  // Configuration register
  // --------------------------------------------------------------------------
  logic [MW-1:0] msize_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      msize_r <= ifd_pkg::MSIZE_RESET;
    end else if (cfg_wr_en) begin
      msize_r <= cfg_wr_data;
    end
  end

  // --------------------------------------------------------------------------
  // Handshake: the input stage advances whenever the result register is
  // empty or its result is being taken in this cycle. A new transfer is
  // taken whenever the input stage is empty or advancing.
  // --------------------------------------------------------------------------
  logic s1_valid_r;
  logic out_valid_r;
  logic s1_adv;
  logic in_xfer;

  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_xfer  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_xfer) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Input register: payload only, held until the next transfer
  logic [AW-1:0] s1_pc_r;
  logic [7:0]    s1_op_r;
  logic [7:0]    s1_rbyte_r;
  logic [WW-1:0] s1_w1_r;
  logic [WW-1:0] s1_w2_r;

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_pc_r    <= in_fetch_address;
      s1_op_r    <= in_opcode_byte;
      s1_rbyte_r <= in_register_byte;
      s1_w1_r    <= in_word_after_opcode;
      s1_w2_r    <= in_word_after_registers;
    end
  end

  // --------------------------------------------------------------------------
  // Decode
  // --------------------------------------------------------------------------
  logic [NW-1:0] code;
  logic [NW-1:0] fn;
  logic [NW-1:0] ra;
  logic [NW-1:0] rb;
  logic [NW-1:0] fn_max;
  logic          code_ok;
  logic          use_regs;
  logic          use_const;
  logic          const_after_op;
  logic          regs_good;

  assign code = s1_op_r[7:4];
  assign fn   = s1_op_r[3:0];
  assign ra   = s1_rbyte_r[7:4];
  assign rb   = s1_rbyte_r[3:0];

  // Per-code properties: function limit and which extra bytes are used
  always_comb begin
    fn_max         = ifd_pkg::FN_MAX_NONE;
    code_ok        = 1'b1;
    use_regs       = 1'b0;
    use_const      = 1'b0;
    const_after_op = 1'b0;
    unique case (code) inside
      ifd_pkg::CODE_HALT, ifd_pkg::CODE_NOP, ifd_pkg::CODE_RET: begin
        fn_max = ifd_pkg::FN_MAX_NONE;
      end
      ifd_pkg::CODE_CMOV: begin
        fn_max   = ifd_pkg::FN_MAX_COND;
        use_regs = 1'b1;
      end
      ifd_pkg::CODE_IRMOV, ifd_pkg::CODE_RMMOV, ifd_pkg::CODE_MRMOV: begin
        use_regs  = 1'b1;
        use_const = 1'b1;
      end
      ifd_pkg::CODE_OPQ: begin
        fn_max   = ifd_pkg::FN_MAX_OPQ;
        use_regs = 1'b1;
      end
      ifd_pkg::CODE_JXX: begin
        fn_max         = ifd_pkg::FN_MAX_COND;
        use_const      = 1'b1;
        const_after_op = 1'b1;
      end
      ifd_pkg::CODE_CALL: begin
        use_const      = 1'b1;
        const_after_op = 1'b1;
      end
      ifd_pkg::CODE_PUSH, ifd_pkg::CODE_POP: begin
        use_regs = 1'b1;
      end
      ifd_pkg::CODE_IOTRAP: begin
        fn_max = ifd_pkg::FN_MAX_TRAP;
      end
      default: begin
        code_ok = 1'b0;
      end
    endcase
  end

  // Register-number rules per code
  always_comb begin
    unique case (code) inside
      ifd_pkg::CODE_CMOV, ifd_pkg::CODE_OPQ: begin
        regs_good = (ra <= ifd_pkg::TOP_REG) && (rb <= ifd_pkg::TOP_REG);
      end
      ifd_pkg::CODE_IRMOV: begin
        regs_good = (ra == ifd_pkg::NO_REG) && (rb <= ifd_pkg::TOP_REG);
      end
      ifd_pkg::CODE_RMMOV, ifd_pkg::CODE_MRMOV: begin
        regs_good = (ra <= ifd_pkg::TOP_REG);
      end
      default: begin
        regs_good = (ra <= ifd_pkg::TOP_REG) && (rb == ifd_pkg::NO_REG);
      end
    endcase
  end

  // Address checks. Once the opcode byte is inside memory the address fits
  // in MW bits, so the byte offsets only need a couple of extra bits.
  logic          pc_in_mem;
  logic [MW:0]   p_reg;      // address of the register byte
  logic [MW:0]   p_mid;      // address after opcode and any register byte
  logic [MW+1:0] p_end;      // address after the constant
  logic          rbyte_in_mem;
  logic          const_in_mem;

  assign pc_in_mem    = (s1_pc_r[AW-1:MW] == '0) && (s1_pc_r[MW-1:0] < msize_r);
  assign p_reg        = {1'b0, s1_pc_r[MW-1:0]} + {{MW{1'b0}}, 1'b1};
  assign rbyte_in_mem = p_reg < {1'b0, msize_r};
  assign p_mid        = use_regs ? (p_reg + {{MW{1'b0}}, 1'b1}) : p_reg;
  assign p_end        = {1'b0, p_mid} + {{(MW-2){1'b0}}, ifd_pkg::CONST_BYTES};
  assign const_in_mem = !(p_end > {2'b00, msize_r});

  // First failing check sets the status
  ifd_pkg::status_t st;

  always_comb begin
    if (!pc_in_mem) begin
      st = ifd_pkg::ST_ADR;
    end else if (!code_ok || (fn > fn_max)) begin
      st = ifd_pkg::ST_INS;
    end else if (use_regs && !rbyte_in_mem) begin
      st = ifd_pkg::ST_ADR;
    end else if (use_regs && !regs_good) begin
      st = ifd_pkg::ST_INS;
    end else if (use_const && !const_in_mem) begin
      st = ifd_pkg::ST_ADR;
    end else begin
      st = ifd_pkg::ST_OK;
    end
  end

  // --------------------------------------------------------------------------
  // Result register: zero the fields, with NO_REG as registers, of a faulting instruction
  // --------------------------------------------------------------------------
  logic [1:0]    o_status_r;
  logic [NW-1:0] o_code_r;
  logic [NW-1:0] o_fn_r;
  logic [NW-1:0] o_ra_r;
  logic [NW-1:0] o_rb_r;
  logic [WW-1:0] o_const_r;
  logic [AW-1:0] o_next_r;

  logic          is_ok;
  logic [WW-1:0] const_sel;
  logic [MW+1:0] next_lo;

  assign is_ok     = (st == ifd_pkg::ST_OK);
  assign const_sel = !use_const ? '0 : (const_after_op ? s1_w1_r : s1_w2_r);
  assign next_lo   = use_const ? p_end : {1'b0, p_mid};

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      o_status_r <= st;
      o_code_r   <= is_ok ? code : '0;
      o_fn_r     <= is_ok ? fn : '0;
      o_ra_r     <= (is_ok && use_regs) ? ra : ifd_pkg::NO_REG;
      o_rb_r     <= (is_ok && use_regs) ? rb : ifd_pkg::NO_REG;
      o_const_r  <= is_ok ? const_sel : '0;
      o_next_r   <= is_ok ? {{(AW-MW-2){1'b0}}, next_lo} : '0;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = o_status_r;
  assign out_instr_code     = o_code_r;
  assign out_instr_function = o_fn_r;
  assign out_reg_a          = o_ra_r;
  assign out_reg_b          = o_rb_r;
  assign out_constant_value = o_const_r;
  assign out_next_address   = o_next_r;

`ifndef ASSERT_OFF
  // a good decode has a nonzero next address that fits in 18 bits
  a_ok_next : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && o_status_r == ifd_pkg::ST_OK) |->
      (o_next_r[AW-1:MW+1] == '0) && (o_next_r != '0))
    else $error("ok result with next address out of range");

  // a faulting decode carries zeroed fields and NO_REG registers
  a_bad_clear : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && o_status_r != ifd_pkg::ST_OK) |->
      (o_code_r == '0) && (o_fn_r == '0) && (o_ra_r == ifd_pkg::NO_REG) &&
      (o_rb_r == ifd_pkg::NO_REG) && (o_const_r == '0) && (o_next_r == '0))
    else $error("faulting result with stray fields");

  // input stalls only when both stages are full and the output is blocked
  a_stall_cause : assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s1_valid_r && out_valid_r && !out_ready))
    else $error("input stalled without a full pipeline");

  // a valid result never carries the unused status code
  a_status_code : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(o_status_r == 2'b11))
    else $error("undefined status code");
`endif

endmodule
